/* sv/indexed_list_engine_assert.svh */
// ----------------------------------------------------------------------------
// indexed_list_engine assertion macros
// Shared property wrappers for the list engine checks.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, gated by reset
`define ILE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ile check failed");

// next-cycle implication, gated by reset
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ile check failed");

`endif

/* sv/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg
// Types and constants shared by the indexed list engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

	localparam int CAPACITY = 64;
	localparam int ELEM_W   = 32;
	localparam int POS_W    = 7;
	localparam int CNT_W    = 7;
	localparam int IDX_W    = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// what each cell does on the execute edge
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_REM  = 2'd2,
		OP_WR   = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [ELEM_W-1:0] val;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* sv/indexed_list_engine.sv */
// Flow: a request accepted at start is held in the request register, executed on the
// cell row while busy is high, and its result strobes on done during the cycle that follows.
// Throughput: start is ignored while busy, so a new request is taken only after the
// one-step update of the cell row; busy stays high for the execute cycle only.
// Reset: arst_n clears the element count (empty list), busy and done; cell contents
// are not cleared, since only positions below the count are ever read.
// ----------------------------------------------------------------------------
// indexed_list_engine
// Positional list of up to CAPACITY elements held in a row of shift cells.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    cmd,
	input  wire logic [ile_pkg::POS_W-1:0]     position,
	input  wire logic [ile_pkg::ELEM_W-1:0]    element_in,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [ile_pkg::ELEM_W-1:0]         element_out,
	output logic [ile_pkg::CNT_W-1:0]          list_length
);

	// Each cell holds one slot. On insert every slot above the position takes its
	// left neighbor, the slot at the position takes the new element. On remove
	// the slot at and above the position take their right neighbor.
	ile_pkg::cell_ctl_t              ctl;
	ile_pkg::status_t                status_w;
	logic [ile_pkg::ELEM_W-1:0]      cell_data [ile_pkg::CAPACITY];
	logic [ile_pkg::ELEM_W-1:0]      rd_data;

	ile_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.position    (position),
		.element_in  (element_in),
		.rd_data     (rd_data),
		.busy        (busy),
		.ctl         (ctl),
		.done        (done),
		.status      (status_w),
		.element_out (element_out),
		.list_length (list_length)
	);

	assign status = status_w;

	for (genvar g = 0; g < ile_pkg::CAPACITY; g++) begin : g_cell
		logic [ile_pkg::ELEM_W-1:0] left_w;
		logic [ile_pkg::ELEM_W-1:0] right_w;

		// ends of the row: the first cell never shifts from the left, and the
		// last cell's value past the count is never read, so it keeps its own
		if (g == 0) begin : g_first
			assign left_w = ctl.val;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == ile_pkg::CAPACITY - 1) begin : g_last
			assign right_w = cell_data[g];
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		ile_cell u_cell (
			.clk   (clk),
			.slot  (ile_pkg::IDX_W'(g)),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[g])
		);
	end

	// read port: select the slot at the request position
	assign rd_data = cell_data[ctl.idx];

endmodule

`default_nettype wire

/* sv/ile_cell.sv */
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds an element and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell (
	input  wire logic                          clk,
	input  wire logic [ile_pkg::IDX_W-1:0]     slot,
	input  wire ile_pkg::cell_ctl_t            ctl,
	input  wire logic [ile_pkg::ELEM_W-1:0]    left,
	input  wire logic [ile_pkg::ELEM_W-1:0]    right,
	output logic      [ile_pkg::ELEM_W-1:0]    data
);

	logic [ile_pkg::ELEM_W-1:0] data_q;
	logic [ile_pkg::ELEM_W-1:0] data_d;
	logic                       hit;
	logic                       above;

	assign hit   = (slot == ctl.idx);
	assign above = (slot > ctl.idx);

	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			ile_pkg::OP_INS: begin
				if (hit) data_d = ctl.val;
				else if (above) data_d = left;
			end
			ile_pkg::OP_REM: begin
				if (hit || above) data_d = right;
			end
			ile_pkg::OP_WR: begin
				if (hit) data_d = ctl.val;
			end
			default: data_d = data_q;
		endcase
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

/* sv/ile_ctrl.sv */
// ----------------------------------------------------------------------------
// ile_ctrl
// Request capture, range checks, count tracking and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_engine_assert.svh"

module ile_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [1:0]                    cmd,
	input  wire logic [ile_pkg::POS_W-1:0]     position,
	input  wire logic [ile_pkg::ELEM_W-1:0]    element_in,
	input  wire logic [ile_pkg::ELEM_W-1:0]    rd_data,
	output logic                               busy,
	output ile_pkg::cell_ctl_t                 ctl,
	output logic                               done,
	output ile_pkg::status_t                   status,
	output logic      [ile_pkg::ELEM_W-1:0]    element_out,
	output logic      [ile_pkg::CNT_W-1:0]     list_length
);

	localparam logic [ile_pkg::CNT_W-1:0] CAP_CNT = ile_pkg::CNT_W'(ile_pkg::CAPACITY);

	logic                         busy_q;
	ile_pkg::cmd_t                cmd_q;
	logic [ile_pkg::POS_W-1:0]    pos_q;
	logic [ile_pkg::ELEM_W-1:0]   val_q;
	logic [ile_pkg::CNT_W-1:0]    count_q;
	logic                         done_q;
	ile_pkg::status_t             status_q;
	logic [ile_pkg::ELEM_W-1:0]   eout_q;

	ile_pkg::status_t             st_d;
	ile_pkg::op_t                 op_d;
	logic [ile_pkg::CNT_W-1:0]    count_d;
	logic                         accept;
	logic [ile_pkg::CNT_W-1:0]    pos_ext;

	assign accept  = start && !busy_q;
	assign pos_ext = ile_pkg::CNT_W'(pos_q);

	// check and decode during the execute cycle
	always_comb begin
		st_d    = ile_pkg::ST_OK;
		op_d    = ile_pkg::OP_HOLD;
		count_d = count_q;
		unique case (cmd_q)
			ile_pkg::CMD_INSERT: begin
				if (pos_ext > count_q) st_d = ile_pkg::ST_BAD_INDEX;
				else if (count_q >= CAP_CNT) st_d = ile_pkg::ST_FULL;
				else begin
					op_d    = ile_pkg::OP_INS;
					count_d = count_q + 1'b1;
				end
			end
			ile_pkg::CMD_READ: begin
				if (pos_ext >= count_q) st_d = ile_pkg::ST_BAD_INDEX;
			end
			ile_pkg::CMD_WRITE: begin
				if (pos_ext >= count_q) st_d = ile_pkg::ST_BAD_INDEX;
				else op_d = ile_pkg::OP_WR;
			end
			ile_pkg::CMD_REMOVE: begin
				if (pos_ext >= count_q) st_d = ile_pkg::ST_BAD_INDEX;
				else begin
					op_d    = ile_pkg::OP_REM;
					count_d = count_q - 1'b1;
				end
			end
			default: st_d = ile_pkg::ST_BAD_INDEX;
		endcase
		if (!busy_q) begin
			op_d    = ile_pkg::OP_HOLD;
			count_d = count_q;
		end
	end

	assign ctl.op  = op_d;
	assign ctl.idx = pos_q[ile_pkg::IDX_W-1:0];
	assign ctl.val = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q  <= accept;
			done_q  <= busy_q;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= ile_pkg::cmd_t'(cmd);
			pos_q <= position;
			val_q <= element_in;
		end
		if (busy_q) begin
			status_q <= st_d;
			eout_q   <= (cmd_q == ile_pkg::CMD_READ && st_d == ile_pkg::ST_OK) ?
				rd_data : '0;
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign element_out = eout_q;
	assign list_length = count_q;

	`ILE_ASSERT_NEXT(a_req_gives_result, clk, arst_n, busy_q, done_q)
	`ILE_ASSERT_NEXT(a_accept_sets_busy, clk, arst_n, accept, busy_q)
	`ILE_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CAP_CNT)
	`ILE_ASSERT_NOW(a_err_zero_data, clk, arst_n, done_q && status_q != ile_pkg::ST_OK, eout_q == '0)
	`ILE_ASSERT_NOW(a_full_at_cap, clk, arst_n, done_q && status_q == ile_pkg::ST_FULL, count_q == CAP_CNT)

endmodule

`default_nettype wire
